// ===== sv/blru_pkg.sv =====
// Shared constants for the budget LRU eviction select block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package blru_pkg;

	// fixed field widths of the item and result channels
	localparam int COST_W    = 32;
	localparam int FRAME_W   = 32;
	localparam int BUDGET_W  = 32;
	localparam int IN_DEPTH_W = 8;
	localparam int OUT_IDX_W = 6;

	// depth of the queue between front and back
	localparam int QDEPTH = 2;

endpackage

// ===== sv/blru_front.sv =====
// Front part: accepts fragments and keeps them sorted in a row of cells.
// After the final fragment it drains the row, newest first, into the queue.
// Depends on blru_pkg.
`timescale 1ns / 1ps

module blru_front import blru_pkg::*; #(
	parameter int MAX_ENTRIES = 64,
	parameter int DEPTH_BITS  = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [COST_W-1:0]     fragment_cost,
	input  logic [FRAME_W-1:0]    use_frame,
	input  logic [IN_DEPTH_W-1:0] node_depth,
	input  logic                  final_entry,
	input  logic                  push,
	output logic                  full,
	output logic                  q_push,
	input  logic                  q_full,
	output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] q_index,
	output logic [COST_W-1:0]     q_cost,
	output logic                  q_tail
);

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [1:0] {
		F_LOAD  = 2'b01,
		F_DRAIN = 2'b10
	} front_state_t;

	front_state_t state_q;
	logic [CNT_W-1:0] count_q;

	// cell row: position 0 holds the newest entry of the eviction order
	logic [FRAME_W-1:0]    cell_frame_q [MAX_ENTRIES];
	logic [DEPTH_BITS-1:0] cell_depth_q [MAX_ENTRIES];
	logic [COST_W-1:0]     cell_cost_q  [MAX_ENTRIES];
	logic [IDX_W-1:0]      cell_idx_q   [MAX_ENTRIES];
	logic                  cell_vld_q   [MAX_ENTRIES];

	logic                  new_before [MAX_ENTRIES];
	logic                  cell_after [MAX_ENTRIES];
	logic                  take_new   [MAX_ENTRIES];
	logic                  take_prev  [MAX_ENTRIES];
	logic [DEPTH_BITS-1:0] new_depth;
	logic                  accept;
	logic                  ins;
	logic                  drain;

	assign new_depth = DEPTH_BITS'(node_depth);
	assign full      = (state_q != F_LOAD);
	assign accept    = push && !full;
	assign ins       = accept && (count_q < CNT_W'(MAX_ENTRIES));
	assign drain     = (state_q == F_DRAIN) && !q_full;

	// compare the new fragment against every cell; empty cells sit past the end
	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			new_before[i] = (use_frame < cell_frame_q[i]) ||
				((use_frame == cell_frame_q[i]) &&
				 ((new_depth > cell_depth_q[i]) ||
				  ((new_depth == cell_depth_q[i]) && (fragment_cost > cell_cost_q[i]))));
			cell_after[i] = !cell_vld_q[i] || !new_before[i];
		end
		take_new[0]  = cell_after[0];
		take_prev[0] = 1'b0;
		for (int i = 1; i < MAX_ENTRIES; i++) begin
			take_new[i]  = cell_after[i] && !cell_after[i-1];
			take_prev[i] = cell_after[i-1];
		end
	end

	// insert by shifting up, drain by shifting down
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		always_ff @(posedge clk) begin
			if (ins) begin
				if (take_new[i]) begin
					cell_frame_q[i] <= use_frame;
					cell_depth_q[i] <= new_depth;
					cell_cost_q[i]  <= fragment_cost;
					cell_idx_q[i]   <= count_q[IDX_W-1:0];
				end else if (take_prev[i]) begin
					if (i > 0) begin
						cell_frame_q[i] <= cell_frame_q[(i > 0) ? i - 1 : 0];
						cell_depth_q[i] <= cell_depth_q[(i > 0) ? i - 1 : 0];
						cell_cost_q[i]  <= cell_cost_q[(i > 0) ? i - 1 : 0];
						cell_idx_q[i]   <= cell_idx_q[(i > 0) ? i - 1 : 0];
					end
				end
			end else if (drain) begin
				if (i < MAX_ENTRIES - 1) begin
					cell_frame_q[i] <= cell_frame_q[(i < MAX_ENTRIES - 1) ? i + 1 : i];
					cell_depth_q[i] <= cell_depth_q[(i < MAX_ENTRIES - 1) ? i + 1 : i];
					cell_cost_q[i]  <= cell_cost_q[(i < MAX_ENTRIES - 1) ? i + 1 : i];
					cell_idx_q[i]   <= cell_idx_q[(i < MAX_ENTRIES - 1) ? i + 1 : i];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cell_vld_q[i] <= 1'b0;
			end else if (ins) begin
				if (take_new[i]) begin
					cell_vld_q[i] <= 1'b1;
				end else if (take_prev[i]) begin
					cell_vld_q[i] <= cell_vld_q[(i > 0) ? i - 1 : 0];
				end
			end else if (drain) begin
				if (i < MAX_ENTRIES - 1) begin
					cell_vld_q[i] <= cell_vld_q[(i < MAX_ENTRIES - 1) ? i + 1 : i];
				end else begin
					cell_vld_q[i] <= 1'b0;
				end
			end
		end
	end

	// load until the final fragment, then drain the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_LOAD;
			count_q <= '0;
		end else begin
			unique case (state_q)
				F_LOAD: begin
					if (ins) begin
						count_q <= count_q + CNT_W'(1);
					end
					if (accept && final_entry) begin
						state_q <= F_DRAIN;
					end
				end
				F_DRAIN: begin
					if (drain) begin
						count_q <= count_q - CNT_W'(1);
						if (count_q == CNT_W'(1)) begin
							state_q <= F_LOAD;
						end
					end
				end
				default: begin
					state_q <= F_LOAD;
				end
			endcase
		end
	end

	assign q_push  = drain;
	assign q_index = cell_idx_q[0];
	assign q_cost  = cell_cost_q[0];
	assign q_tail  = (count_q == CNT_W'(1));

endmodule

// ===== sv/blru_queue.sv =====
// Short FIFO that decouples the front sorter from the back walker.
// Depends on blru_pkg for its depth.
`timescale 1ns / 1ps

module blru_queue import blru_pkg::*; #(
	parameter int WIDTH = 39
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             q_full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             q_empty
);

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W = $clog2(QDEPTH + 1);

	logic [WIDTH-1:0] slot_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign q_full  = (count_q == CNT_W'(QDEPTH));
	assign q_empty = (count_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_data = slot_q[rd_ptr_q];

	// store the request payload
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			priority if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end else begin
				count_q <= count_q;
			end
		end
	end

endmodule

// ===== sv/blru_back.sv =====
// Back part: walks the sorted stream against the byte budget, keeps the
// indices in a memory and emits the evicted prefix oldest first.
// Depends on blru_pkg.
`timescale 1ns / 1ps

module blru_back import blru_pkg::*; #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 budget_we,
	input  logic [BUDGET_W-1:0]  byte_budget,
	input  logic                 q_empty,
	output logic                 q_pop,
	input  logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] q_index,
	input  logic [COST_W-1:0]    q_cost,
	input  logic                 q_tail,
	input  logic                 pop,
	output logic                 empty,
	output logic [OUT_IDX_W-1:0] evict_index,
	output logic                 evict_valid,
	output logic                 run_end
);

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [1:0] {
		B_COLLECT = 2'b01,
		B_EMIT    = 2'b10
	} back_state_t;

	back_state_t         state_q;
	logic [BUDGET_W-1:0] budget_q;
	logic [IDX_W-1:0]    order_q [MAX_ENTRIES];
	logic [CNT_W-1:0]    wr_q;
	logic [CNT_W-1:0]    kept_q;
	logic [BUDGET_W-1:0] kept_bytes_q;
	logic                stop_q;
	logic [CNT_W-1:0]    rd_q;
	logic                none_q;
	logic                pend_q;
	logic                pend_end_q;
	logic [IDX_W-1:0]    rd_data_q;
	logic                out_vld_q;
	logic [OUT_IDX_W-1:0] out_idx_q;
	logic                out_evict_q;
	logic                out_end_q;

	logic [BUDGET_W-1:0] room;
	logic                fit;
	logic [CNT_W-1:0]    kept_next;
	logic [CNT_W-1:0]    wr_next;
	logic [CNT_W-1:0]    rd_m1;
	logic                take;
	logic                out_free;
	logic                issue;
	logic                load_none;
	logic                load_pend;

	assign room      = budget_q - kept_bytes_q;
	assign fit       = !stop_q && (q_cost <= room);
	assign kept_next = fit ? kept_q + CNT_W'(1) : kept_q;
	assign wr_next   = wr_q + CNT_W'(1);
	assign rd_m1     = rd_q - CNT_W'(1);
	assign q_pop     = (state_q == B_COLLECT);
	assign take      = q_pop && !q_empty;
	assign out_free  = !out_vld_q || pop;
	assign issue     = (state_q == B_EMIT) && !none_q && (rd_q != kept_q) && !pend_q && out_free;
	assign load_none = (state_q == B_EMIT) && none_q && out_free;
	assign load_pend = (state_q == B_EMIT) && pend_q;

	// hold the budget register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= '0;
		end else if (budget_we) begin
			budget_q <= byte_budget;
		end
	end

	// write the stream into the order memory, read it back in reverse
	always_ff @(posedge clk) begin
		if (take) begin
			order_q[wr_q[IDX_W-1:0]] <= q_index;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_data_q <= order_q[rd_m1[IDX_W-1:0]];
		end
	end

	// collect the run, then emit it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_COLLECT;
			wr_q         <= '0;
			kept_q       <= '0;
			kept_bytes_q <= '0;
			stop_q       <= 1'b0;
			rd_q         <= '0;
			none_q       <= 1'b0;
			pend_q       <= 1'b0;
			pend_end_q   <= 1'b0;
		end else begin
			unique case (state_q)
				B_COLLECT: begin
					if (take) begin
						kept_q <= kept_next;
						if (q_tail) begin
							rd_q         <= wr_next;
							none_q       <= (wr_next == kept_next);
							wr_q         <= '0;
							kept_bytes_q <= '0;
							stop_q       <= 1'b0;
							state_q      <= B_EMIT;
						end else begin
							wr_q <= wr_next;
							if (fit) begin
								kept_bytes_q <= kept_bytes_q + q_cost;
							end else begin
								stop_q <= 1'b1;
							end
						end
					end
				end
				B_EMIT: begin
					if (issue) begin
						rd_q       <= rd_m1;
						pend_q     <= 1'b1;
						pend_end_q <= (rd_m1 == kept_q);
					end
					if (load_pend) begin
						pend_q <= 1'b0;
					end
					if (load_none || (load_pend && pend_end_q)) begin
						kept_q  <= '0;
						state_q <= B_COLLECT;
					end
				end
				default: begin
					state_q <= B_COLLECT;
				end
			endcase
		end
	end

	// hold the result until it is popped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_none || load_pend) begin
			out_vld_q <= 1'b1;
		end else if (pop) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_none) begin
			out_idx_q   <= '0;
			out_evict_q <= 1'b0;
			out_end_q   <= 1'b1;
		end else if (load_pend) begin
			out_idx_q   <= OUT_IDX_W'(rd_data_q);
			out_evict_q <= 1'b1;
			out_end_q   <= pend_end_q;
		end
	end

	assign empty       = !out_vld_q;
	assign evict_index = out_idx_q;
	assign evict_valid = out_evict_q;
	assign run_end     = out_end_q;

endmodule

// ===== sv/budget_lru_eviction_select_core.sv =====
// Top level of the budget LRU eviction select block.
// Depends on blru_pkg, blru_front, blru_queue and blru_back.
//
// Usage:
//   Fragments enter through a queue-style port: an item is taken at a clock
//   edge with push high and full low. Each fragment gets its arrival index and
//   is inserted into a sorted cell row, so a set loads at one fragment per
//   cycle. Fragments beyond MAX_ENTRIES are dropped, but their final_entry
//   mark still ends the set.
//   After the final fragment, full stays high while the row drains into the
//   back part, one entry per cycle while the queue has room; the next set can
//   load as soon as full drops, while the back part still emits.
//   The back part checks each entry against byte_budget as it arrives, then
//   emits the evicted indices oldest first while the receiver pops; it loads
//   each index from memory into the output before reading the next. A run
//   with no eviction gives one result with evict_valid low and run_end high.
//   Results wait on the output ports while empty is low and leave on pop; a
//   stalled receiver holds the result and backs up through the queue into the
//   drain, never losing an entry.
//   byte_budget is written by budget_we, with no wait; write it only while the
//   block idles, which the block itself does not enforce. Reset clears the
//   budget, fill counts and row valid bits; the stores need no clearing pass.
`timescale 1ns / 1ps

module budget_lru_eviction_select_core import blru_pkg::*; #(
	parameter int MAX_ENTRIES = 64,
	parameter int DEPTH_BITS  = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  budget_we,
	input  logic [BUDGET_W-1:0]   byte_budget,
	input  logic [COST_W-1:0]     fragment_cost,
	input  logic [FRAME_W-1:0]    use_frame,
	input  logic [IN_DEPTH_W-1:0] node_depth,
	input  logic                  final_entry,
	input  logic                  push,
	output logic                  full,
	output logic [OUT_IDX_W-1:0]  evict_index,
	output logic                  evict_valid,
	output logic                  run_end,
	output logic                  empty,
	input  logic                  pop
);

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int Q_W   = IDX_W + COST_W + 1;

	logic             f_push;
	logic [IDX_W-1:0] f_index;
	logic [COST_W-1:0] f_cost;
	logic             f_tail;
	logic             q_full;
	logic             q_empty;
	logic             q_pop;
	logic [Q_W-1:0]   q_rd_data;

	blru_front #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.DEPTH_BITS (DEPTH_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.fragment_cost(fragment_cost),
		.use_frame    (use_frame),
		.node_depth   (node_depth),
		.final_entry  (final_entry),
		.push         (push),
		.full         (full),
		.q_push       (f_push),
		.q_full       (q_full),
		.q_index      (f_index),
		.q_cost       (f_cost),
		.q_tail       (f_tail)
	);

	blru_queue #(
		.WIDTH(Q_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (f_push),
		.wr_data({f_tail, f_cost, f_index}),
		.q_full (q_full),
		.rd_en  (q_pop),
		.rd_data(q_rd_data),
		.q_empty(q_empty)
	);

	blru_back #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.budget_we  (budget_we),
		.byte_budget(byte_budget),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.q_index    (q_rd_data[IDX_W-1:0]),
		.q_cost     (q_rd_data[IDX_W+COST_W-1:IDX_W]),
		.q_tail     (q_rd_data[Q_W-1]),
		.pop        (pop),
		.empty      (empty),
		.evict_index(evict_index),
		.evict_valid(evict_valid),
		.run_end    (run_end)
	);

endmodule

// ===== sv/blru_checker.sv =====
// Port-level checks for budget_lru_eviction_select_core, bound to the top.
// Depends on blru_pkg and the top level's port list.
`timescale 1ns / 1ps

module blru_checker import blru_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 push,
	input logic                 full,
	input logic                 final_entry,
	input logic                 pop,
	input logic                 empty,
	input logic [OUT_IDX_W-1:0] evict_index,
	input logic                 evict_valid,
	input logic                 run_end
);

	// hold a stalled result
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(evict_index) &&
			$stable(evict_valid) && $stable(run_end)))
		else $error("stalled result changed or vanished");

	// a no-eviction result closes the run
	a_none_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !evict_valid) |-> run_end)
		else $error("no-eviction result without run end");

	// a no-eviction result carries index zero
	a_none_index: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !evict_valid) |-> (evict_index == '0))
		else $error("no-eviction result with nonzero index");

	// stop taking requests once the set is closed
	a_full_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && final_entry) |=> full)
		else $error("input open right after final fragment");

endmodule

bind budget_lru_eviction_select_core blru_checker u_blru_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.push       (push),
	.full       (full),
	.final_entry(final_entry),
	.pop        (pop),
	.empty      (empty),
	.evict_index(evict_index),
	.evict_valid(evict_valid),
	.run_end    (run_end)
);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for budget_lru_eviction_select_core.
// Depends on blru_pkg and the core; a scoreboard class predicts the evicted
// indices of each fragment set and checks them against every popped result.
`timescale 1ns / 1ps

module tb;
	import blru_pkg::*;

	localparam int FRAG_SLOTS = 64;
	localparam int DEPTH_BITS = 8;
	localparam logic [IN_DEPTH_W-1:0] DEPTH_MASK = IN_DEPTH_W'((1 << DEPTH_BITS) - 1);
	localparam logic [BUDGET_W-1:0] BUDGET_MAX = '1;
	// cycles to let the back part settle before a budget write
	localparam int SETTLE_CYCLES = 150;
	localparam int DRAIN_CYCLES = 200;
	localparam time RUN_LIMIT = 4ms;

	typedef struct packed {
		logic [OUT_IDX_W-1:0] evict;
		logic                 valid;
		logic                 closes;
	} eviction_t;

	// Sorted fragment set and the evictions still owed by the block
	class evict_tracker;
		logic [COST_W-1:0]     cost_mem[FRAG_SLOTS];
		logic [FRAME_W-1:0]    frame_mem[FRAG_SLOTS];
		logic [IN_DEPTH_W-1:0] depth_mem[FRAG_SLOTS];
		int                    rank[FRAG_SLOTS];
		int                    held;
		logic [BUDGET_W-1:0]   budget;
		eviction_t             due_evictions[$];
		int                    fails;

		function new();
			held = 0;
			budget = '0;
			fails = 0;
		endfunction

		// true when fragment a is evicted ahead of fragment b
		function bit older_than(int a, int b);
			if (frame_mem[a] != frame_mem[b])
				return frame_mem[a] < frame_mem[b];
			if (depth_mem[a] != depth_mem[b])
				return depth_mem[a] > depth_mem[b];
			if (cost_mem[a] != cost_mem[b])
				return cost_mem[a] > cost_mem[b];
			return a < b;
		endfunction

		// Insert an accepted fragment; on the final one, queue its evictions
		function void take_fragment(logic [COST_W-1:0] c, logic [FRAME_W-1:0] f,
				logic [IN_DEPTH_W-1:0] d, logic fin);
			int pos;
			int first_kept;
			logic [BUDGET_W-1:0] kept;
			eviction_t e;
			if (held < FRAG_SLOTS) begin
				cost_mem[held] = c;
				frame_mem[held] = f;
				depth_mem[held] = d & DEPTH_MASK;
				pos = held;
				while (pos > 0 && older_than(held, rank[pos-1])) begin
					rank[pos] = rank[pos-1];
					pos--;
				end
				rank[pos] = held;
				held++;
			end
			if (!fin)
				return;
			// keep the newest suffix while it fits, stop at the first misfit
			kept = '0;
			first_kept = held;
			while (first_kept > 0 && cost_mem[rank[first_kept-1]] <= budget - kept) begin
				kept = kept + cost_mem[rank[first_kept-1]];
				first_kept--;
			end
			if (first_kept == 0) begin
				e.evict = '0;
				e.valid = 1'b0;
				e.closes = 1'b1;
				due_evictions = {due_evictions, e};
			end else begin
				for (int k = 0; k < first_kept; k++) begin
					e.evict = OUT_IDX_W'(rank[k]);
					e.valid = 1'b1;
					e.closes = (k == first_kept - 1);
					due_evictions = {due_evictions, e};
				end
			end
			held = 0;
		endfunction

		// Compare a popped result with the oldest owed eviction
		function void match_eviction(logic [OUT_IDX_W-1:0] idx, logic vld, logic lst);
			eviction_t want;
			if (due_evictions.size() == 0) begin
				$display("%0t: unexpected result: evict_index %0d evict_valid %0b run_end %0b",
					$time, idx, vld, lst);
				fails++;
				return;
			end
			want = due_evictions.pop_front();
			if (idx !== want.evict) begin
				$display("%0t: evict_index expected %0d actual %0d", $time, want.evict, idx);
				fails++;
			end
			if (vld !== want.valid) begin
				$display("%0t: evict_valid expected %0b actual %0b", $time, want.valid, vld);
				fails++;
			end
			if (lst !== want.closes) begin
				$display("%0t: run_end expected %0b actual %0b", $time, want.closes, lst);
				fails++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  budget_we = 1'b0;
	logic [BUDGET_W-1:0]   byte_budget = '0;
	logic [COST_W-1:0]     fragment_cost = '0;
	logic [FRAME_W-1:0]    use_frame = '0;
	logic [IN_DEPTH_W-1:0] node_depth = '0;
	logic                  final_entry = 1'b0;
	logic                  push = 1'b0;
	logic                  full;
	logic [OUT_IDX_W-1:0]  evict_index;
	logic                  evict_valid;
	logic                  run_end;
	logic                  empty;
	logic                  pop = 1'b0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	evict_tracker book;

	budget_lru_eviction_select_core #(
		.MAX_ENTRIES(FRAG_SLOTS),
		.DEPTH_BITS (DEPTH_BITS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.budget_we    (budget_we),
		.byte_budget  (byte_budget),
		.fragment_cost(fragment_cost),
		.use_frame    (use_frame),
		.node_depth   (node_depth),
		.final_entry  (final_entry),
		.push         (push),
		.full         (full),
		.evict_index  (evict_index),
		.evict_valid  (evict_valid),
		.run_end      (run_end),
		.empty        (empty),
		.pop          (pop)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Check each popped result, then stall pop at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				book.match_eviction(evict_index, evict_valid, run_end);
			pop <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Offer one fragment, idling first at random, and hold it until taken
	task automatic send_fragment(input logic [COST_W-1:0] c, input logic [FRAME_W-1:0] f,
			input logic [IN_DEPTH_W-1:0] d, input logic fin);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		fragment_cost <= c;
		use_frame <= f;
		node_depth <= d;
		final_entry <= fin;
		@(posedge clk);
		while (full)
			@(posedge clk);
		book.take_fragment(c, f, d, fin);
	endtask

	// Wait for the block to go idle, then write the budget
	task automatic set_budget(input logic [BUDGET_W-1:0] value);
		push <= 1'b0;
		@(posedge clk);
		while (book.due_evictions.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		budget_we <= 1'b1;
		byte_budget <= value;
		@(posedge clk);
		budget_we <= 1'b0;
		book.budget = value;
	endtask

	// One set of random fragments; field styles vary per set to hit ties
	task automatic send_random_set(input int size);
		int cost_style;
		int frame_style;
		int depth_style;
		logic [COST_W-1:0] c;
		logic [FRAME_W-1:0] f;
		logic [IN_DEPTH_W-1:0] d;
		cost_style = $urandom_range(0, 3);
		frame_style = $urandom_range(0, 2);
		depth_style = $urandom_range(0, 1);
		for (int i = 0; i < size; i++) begin
			case (cost_style)
				0: c = $urandom_range(0, 300);
				1: c = $urandom;
				2: begin
					case ($urandom_range(0, 3))
						0: c = '0;
						1: c = 1;
						2: c = '1;
						default: c = $urandom_range(0, 50);
					endcase
				end
				default: c = $urandom_range(0, 3000);
			endcase
			case (frame_style)
				0: f = $urandom_range(0, 7);
				1: f = $urandom;
				default: f = 32'hFFFF_FFF0 + $urandom_range(0, 15);
			endcase
			d = depth_style ? IN_DEPTH_W'($urandom) : IN_DEPTH_W'($urandom_range(0, 3));
			send_fragment(c, f, d, i == size - 1);
		end
	endtask

	// Write the budget, set the idle mix and send about the given item count
	task automatic run_phase(input logic [BUDGET_W-1:0] value, input int idle_pct,
			input int stall_pct, input int items, input int big_set);
		int sent;
		int size;
		int pick;
		set_budget(value);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		if (big_set > 0) begin
			send_random_set(big_set);
			sent = big_set;
		end
		while (sent < items) begin
			pick = $urandom_range(0, 9);
			if (pick < 6)
				size = $urandom_range(1, 6);
			else if (pick < 9)
				size = $urandom_range(7, 16);
			else
				size = $urandom_range(17, 40);
			send_random_set(size);
			sent += size;
		end
	endtask

	initial begin
		book = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero budget: a free fragment stays, a costly one goes
		set_budget('0);
		send_fragment('0, '0, '0, 1'b1);
		send_fragment('1, '1, '1, 1'b1);

		// full budget: depth, cost and index tie-breaks; wide cost stops the walk
		set_budget(BUDGET_MAX);
		send_fragment('1, 32'd10, 8'd3, 1'b0);
		send_fragment(32'd1, 32'd10, 8'd3, 1'b0);
		send_fragment(32'd1, 32'd10, 8'd3, 1'b0);
		send_fragment('0, 32'd10, 8'd200, 1'b0);
		send_fragment(32'd7, '0, '0, 1'b1);

		// small budget: stop at the first misfit even though older ones would fit
		set_budget(32'd100);
		send_fragment(32'd10, 32'd1, 8'd0, 1'b0);
		send_fragment(32'd5, 32'd2, 8'd0, 1'b0);
		send_fragment(32'd200, 32'd3, 8'd0, 1'b0);
		send_fragment(32'd30, 32'd4, 8'd0, 1'b0);
		send_fragment(32'd60, 32'd5, 8'd0, 1'b1);
		// everything fits: no eviction
		send_fragment(32'd40, 32'd9, 8'd1, 1'b0);
		send_fragment(32'd60, 32'd8, 8'd2, 1'b1);

		// random phases; one set fills the store, another overflows it
		run_phase($urandom_range(0, 1500), 0, 0, 90, 0);
		run_phase(BUDGET_MAX, 59, 0, 90, FRAG_SLOTS);
		run_phase($urandom_range(200, 2000), 0, 59, 90, 0);
		run_phase($urandom, 27, 27, 90, FRAG_SLOTS + $urandom_range(1, 6));
		run_phase('0, 27, 27, 60, 0);
		run_phase($urandom_range(0, 1500), 0, 0, 60, 0);

		// drain the remaining results
		push <= 1'b0;
		@(posedge clk);
		while (book.due_evictions.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (book.fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Hard stop for a hung handshake
	initial begin
		#(RUN_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
sv/blru_pkg.sv
sv/blru_front.sv
sv/blru_queue.sv
sv/blru_back.sv
sv/budget_lru_eviction_select_core.sv
sv/blru_checker.sv
tb/sv/tb.sv
